### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the text line number and escape filter.
// Depends on nothing; included by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, clocked by the block clock named clock and reset named reset.
`define ASSERT_STD(label, prop, msg) \
   `ASSERT_CLK(label, clock, reset, prop, msg)

`endif

### rtl/ltef_pkg.sv
// Package of the text line number and escape filter: register indexes,
// character codes and fixed sizes. Depends on nothing.
`timescale 1ns / 1ps

package ltef_pkg;

   localparam int MAX_OUT   = 15;
   localparam int NUM_FIELD = 6;

   typedef logic [7:0] byte_type;
   typedef logic [3:0] count_type;

   localparam logic [2:0] CSR_NUMBER_MODE      = 3'd0;
   localparam logic [2:0] CSR_SQUEEZE_BLANK    = 3'd1;
   localparam logic [2:0] CSR_SHOW_ENDS        = 3'd2;
   localparam logic [2:0] CSR_CARET_TABS       = 3'd3;
   localparam logic [2:0] CSR_SHOW_NONPRINTING = 3'd4;

   localparam logic [1:0] NUM_NONE         = 2'd0;
   localparam logic [1:0] NUM_ALL          = 2'd1;
   localparam logic [1:0] NUM_NONBLANK     = 2'd2;
   localparam logic [1:0] NUM_NONBLANK_ALT = 2'd3;

   localparam byte_type CH_TAB      = 8'h09;
   localparam byte_type CH_NEWLINE  = 8'h0a;
   localparam byte_type CH_SPACE    = 8'h20;
   localparam byte_type CH_DOLLAR   = 8'h24;
   localparam byte_type CH_MINUS    = 8'h2d;
   localparam byte_type CH_QUESTION = 8'h3f;
   localparam byte_type CH_UPPER_I  = 8'h49;
   localparam byte_type CH_UPPER_M  = 8'h4d;
   localparam byte_type CH_CARET    = 8'h5e;

   localparam byte_type HIGH_BIT    = 8'h80;
   localparam byte_type LOW_MASK    = 8'h7f;
   localparam byte_type CTRL_LIMIT  = 8'h20;
   localparam byte_type CTRL_OFFSET = 8'h40;

endpackage

### rtl/text_line_number_escape_filter.sv
// Top level of the text line number and escape filter.
// Depends on ltef_pkg and assert_macros.svh.
//
// Usage: raw text bytes enter on the req_ channel, one item per byte. Each
// accepted byte is expanded in the same cycle into its complete output
// sequence (optional right-aligned line number and tab, then the byte itself,
// an escape form of it, or a newline with optional dollar sign) and loaded
// into a 15-byte shift buffer. The rsp_ channel then delivers those bytes one
// item per cycle while rsp_ready is high, with rsp_last set on the final
// byte of the sequence. The first output byte appears in the cycle after
// acceptance. The next byte is accepted in the cycle its predecessor's last
// byte is taken, so one input item per cycle is sustained when every byte
// gives one output byte and the receiver does not stall.
// A squeezed blank line is accepted and gives no output item.
// When the receiver stalls, the buffer holds its head byte and req_ready
// stays low while any byte is waiting. Synchronous reset empties the
// buffer, clears the options, sets the line counter to one and marks the
// start of a line. csr_ writes take effect on the next cycle.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module text_line_number_escape_filter
   import ltef_pkg::*;
#(
   parameter int LINE_DIGITS = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   input  logic       csr_write_en,
   input  logic [2:0] csr_index,
   input  logic [1:0] csr_wdata
);

   localparam int NumWidth  = (LINE_DIGITS > NUM_FIELD) ? LINE_DIGITS : NUM_FIELD;
   localparam int NumBytes  = NumWidth + 1;
   localparam int LenW      = $clog2(NumBytes + 5);
   localparam int TopW      = $clog2(LINE_DIGITS);
   localparam int CountBits = 4 * LINE_DIGITS;

   logic [1:0] number_mode_ff;
   logic       squeeze_blank_ff;
   logic       show_ends_ff;
   logic       caret_tabs_ff;
   logic       show_nonprinting_ff;

   logic [CountBits-1:0] line_count_ff, line_count_in;
   logic                 line_head_ff, line_head_in;
   logic                 empty_streak_ff, empty_streak_in;

   byte_type  out_buf_ff [MAX_OUT];
   byte_type  out_buf_in [MAX_OUT];
   count_type count_ff, count_in;

   logic      accept;
   logic      take;
   logic      is_newline;
   logic      squeezed;
   logic      do_number;
   logic      all_nines;
   logic [3:0]      digit [LINE_DIGITS];
   logic [TopW-1:0] top_digit;
   logic [LenW-1:0] field_w;
   logic [LenW-1:0] num_len;
   logic [LenW-1:0] total_len;
   logic [2:0]      tail_len;
   byte_type        tail [4];
   byte_type        num_byte [NumBytes];
   count_type       new_len;

   assign take      = rsp_valid && rsp_ready;
   assign req_ready = (count_ff == '0) || (rsp_ready && count_ff == count_type'(1));
   assign accept    = req_valid && req_ready;

   assign rsp_valid    = (count_ff != '0);
   assign rsp_out_byte = out_buf_ff[0];
   assign rsp_last     = (count_ff == count_type'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         number_mode_ff      <= NUM_NONE;
         squeeze_blank_ff    <= 1'b0;
         show_ends_ff        <= 1'b0;
         caret_tabs_ff       <= 1'b0;
         show_nonprinting_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_NUMBER_MODE:      number_mode_ff      <= csr_wdata;
            CSR_SQUEEZE_BLANK:    squeeze_blank_ff    <= csr_wdata[0];
            CSR_SHOW_ENDS:        show_ends_ff        <= csr_wdata[0];
            CSR_CARET_TABS:       caret_tabs_ff       <= csr_wdata[0];
            CSR_SHOW_NONPRINTING: show_nonprinting_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int d = 0; d < LINE_DIGITS; d++) begin
         digit[d] = line_count_ff[4*d +: 4];
      end
   end

   always_comb begin
      logic carry;
      all_nines     = 1'b1;
      for (int d = 0; d < LINE_DIGITS; d++) begin
         if (digit[d] != 4'd9) begin
            all_nines = 1'b0;
         end
      end
      carry         = 1'b1;
      line_count_in = line_count_ff;
      for (int d = 0; d < LINE_DIGITS; d++) begin
         if (carry) begin
            line_count_in[4*d +: 4] = (digit[d] == 4'd9) ? 4'd0 : 4'(digit[d] + 4'd1);
         end
         carry = carry && (digit[d] == 4'd9);
      end
      if (all_nines) begin
         line_count_in = line_count_ff;
      end
   end

   always_comb begin
      top_digit = '0;
      for (int d = 1; d < LINE_DIGITS; d++) begin
         if (digit[d] != 4'd0) begin
            top_digit = TopW'(d);
         end
      end
      if (int'(top_digit) + 1 < NUM_FIELD) begin
         field_w = LenW'(NUM_FIELD);
      end else begin
         field_w = LenW'(int'(top_digit) + 1);
      end
      for (int k = 0; k < NumBytes; k++) begin
         num_byte[k] = CH_SPACE;
         if (k == int'(field_w)) begin
            num_byte[k] = CH_TAB;
         end else begin
            for (int d = 0; d < LINE_DIGITS; d++) begin
               if (int'(field_w) - 1 - k == d && d <= int'(top_digit)) begin
                  num_byte[k] = {4'h3, digit[d]};
               end
            end
         end
      end
   end

   assign is_newline = (req_in_byte == CH_NEWLINE);
   assign squeezed   = line_head_ff && is_newline && squeeze_blank_ff && empty_streak_ff;

   always_comb begin
      do_number       = 1'b0;
      line_head_in    = line_head_ff;
      empty_streak_in = empty_streak_ff;
      if (line_head_ff) begin
         if (is_newline) begin
            do_number       = !squeezed && (number_mode_ff == NUM_ALL);
            empty_streak_in = 1'b1;
         end else begin
            do_number    = (number_mode_ff != NUM_NONE);
            line_head_in = 1'b0;
            if (squeeze_blank_ff) begin
               empty_streak_in = 1'b0;
            end
         end
      end else if (is_newline) begin
         line_head_in = 1'b1;
      end
   end

   always_comb begin
      byte_type low;
      low = req_in_byte & LOW_MASK;
      for (int j = 0; j < 4; j++) begin
         tail[j] = CH_SPACE;
      end
      tail_len = 3'd1;
      if (is_newline) begin
         if (show_ends_ff) begin
            tail[0]  = CH_DOLLAR;
            tail[1]  = CH_NEWLINE;
            tail_len = 3'd2;
         end else begin
            tail[0] = CH_NEWLINE;
         end
      end else if (req_in_byte == CH_TAB) begin
         if (caret_tabs_ff) begin
            tail[0]  = CH_CARET;
            tail[1]  = CH_UPPER_I;
            tail_len = 3'd2;
         end else begin
            tail[0] = CH_TAB;
         end
      end else if (!show_nonprinting_ff) begin
         tail[0] = req_in_byte;
      end else if ((req_in_byte & HIGH_BIT) != '0) begin
         tail[0] = CH_UPPER_M;
         tail[1] = CH_MINUS;
         if (low < CTRL_LIMIT) begin
            tail[2]  = CH_CARET;
            tail[3]  = low + CTRL_OFFSET;
            tail_len = 3'd4;
         end else if (low == LOW_MASK) begin
            tail[2]  = CH_CARET;
            tail[3]  = CH_QUESTION;
            tail_len = 3'd4;
         end else begin
            tail[2]  = low;
            tail_len = 3'd3;
         end
      end else if (low < CTRL_LIMIT) begin
         tail[0]  = CH_CARET;
         tail[1]  = low + CTRL_OFFSET;
         tail_len = 3'd2;
      end else if (low == LOW_MASK) begin
         tail[0]  = CH_CARET;
         tail[1]  = CH_QUESTION;
         tail_len = 3'd2;
      end else begin
         tail[0] = low;
      end
   end

   always_comb begin
      num_len   = do_number ? LenW'(int'(field_w) + 1) : '0;
      total_len = LenW'(int'(num_len) + int'(tail_len));
      if (squeezed) begin
         new_len = '0;
      end else if (int'(total_len) > MAX_OUT) begin
         new_len = count_type'(MAX_OUT);
      end else begin
         new_len = count_type'(total_len);
      end
      for (int k = 0; k < MAX_OUT; k++) begin
         out_buf_in[k] = CH_SPACE;
         if (k < int'(num_len)) begin
            for (int m = 0; m < NumBytes; m++) begin
               if (m == k) begin
                  out_buf_in[k] = num_byte[m];
               end
            end
         end else begin
            for (int j = 0; j < 4; j++) begin
               if (int'(num_len) + j == k) begin
                  out_buf_in[k] = tail[j];
               end
            end
         end
      end
   end

   always_comb begin
      if (accept) begin
         count_in = new_len;
      end else if (take) begin
         count_in = count_type'(count_ff - count_type'(1));
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         line_count_ff   <= CountBits'(1);
         line_head_ff    <= 1'b1;
         empty_streak_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            line_head_ff    <= line_head_in;
            empty_streak_ff <= empty_streak_in;
            if (do_number) begin
               line_count_ff <= line_count_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_buf_ff <= out_buf_in;
      end else if (take) begin
         for (int k = 0; k < MAX_OUT - 1; k++) begin
            out_buf_ff[k] <= out_buf_ff[k+1];
         end
      end
   end

   `ASSERT_STD(a_stall_holds_count, rsp_valid && !rsp_ready && !accept |=> $stable(count_ff),
      "output count changed while the receiver stalled")
   `ASSERT_STD(a_number_advances,
      accept && do_number && !all_nines |=> line_count_ff != $past(line_count_ff),
      "line counter did not advance after a numbered line")
   `ASSERT_STD(a_newline_sets_start, accept && is_newline |=> line_head_ff,
      "line start flag not set after a newline item")
   `ASSERT_STD(a_squeeze_no_output, accept && squeezed |=> !rsp_valid,
      "squeezed blank line produced output")

endmodule

### dv/tb_text_line_number_escape_filter.sv
// Testbench of text_line_number_escape_filter: directed and random byte streams
// checked against a behavioral predictor. Depends on ltef_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_text_line_number_escape_filter;
   import ltef_pkg::*;

   localparam int LINE_DIGITS = 10;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_ITEMS = 38;
   localparam byte_type CH_ZERO = 8'h30;
   localparam byte_type CH_LOWER_X = 8'h78;

   typedef struct packed {
      byte_type out_byte;
      logic     last;
   } text_result_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;
   logic       csr_write_en;
   logic [2:0] csr_index;
   logic [1:0] csr_wdata;

   logic [1:0] opt_number_mode;
   logic       opt_squeeze_blank;
   logic       opt_show_ends;
   logic       opt_caret_tabs;
   logic       opt_show_nonprinting;
   logic [4*LINE_DIGITS-1:0] line_number;
   logic       line_head;
   logic       empty_streak;

   byte_type        step_bytes[$];
   text_result_type expected_output[$];

   int mismatch_count = 0;
   int bytes_checked = 0;
   int items_sent = 0;
   int settings_applied = 0;
   int idle_cycles = 0;
   int stall_pct = 0;
   int stall_left = 0;
   bit gaps_on = 0;
   int burst_left = 0;

   text_line_number_escape_filter #(
      .LINE_DIGITS(LINE_DIGITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last    (rsp_last),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic void emit(input byte_type b);
      if (step_bytes.size() < MAX_OUT) begin
         step_bytes.push_back(b);
      end
   endfunction

   function automatic void advance_line_number();
      bit saturated;
      saturated = 1;
      for (int i = 0; i < LINE_DIGITS; i++) begin
         if (line_number[4*i +: 4] != 4'd9) begin
            saturated = 0;
         end
      end
      if (saturated) begin
         return;
      end
      for (int i = 0; i < LINE_DIGITS; i++) begin
         if (line_number[4*i +: 4] < 4'd9) begin
            line_number[4*i +: 4] = line_number[4*i +: 4] + 4'd1;
            return;
         end
         line_number[4*i +: 4] = 4'd0;
      end
   endfunction

   function automatic void push_line_label();
      int top;
      count_type digit;
      top = 0;
      for (int i = LINE_DIGITS - 1; i > 0; i--) begin
         if (line_number[4*i +: 4] != 4'd0) begin
            top = i;
            break;
         end
      end
      for (int i = top + 1; i < NUM_FIELD; i++) begin
         emit(CH_SPACE);
      end
      for (int i = top; i >= 0; i--) begin
         digit = line_number[4*i +: 4];
         emit(CH_ZERO + byte_type'(digit));
      end
      emit(CH_TAB);
      advance_line_number();
   endfunction

   function automatic void emit_newline();
      if (opt_show_ends) begin
         emit(CH_DOLLAR);
      end
      emit(CH_NEWLINE);
   endfunction

   function automatic void emit_visible(input byte_type c);
      byte_type low;
      low = c;
      if (c == CH_TAB) begin
         if (opt_caret_tabs) begin
            emit(CH_CARET);
            emit(CH_UPPER_I);
         end else begin
            emit(CH_TAB);
         end
      end else if (!opt_show_nonprinting) begin
         emit(c);
      end else begin
         if ((c & HIGH_BIT) != 8'h00) begin
            emit(CH_UPPER_M);
            emit(CH_MINUS);
            low = c & LOW_MASK;
         end
         if (low < CTRL_LIMIT) begin
            emit(CH_CARET);
            emit(low + CTRL_OFFSET);
         end else if (low == LOW_MASK) begin
            emit(CH_CARET);
            emit(CH_QUESTION);
         end else begin
            emit(low);
         end
      end
   endfunction

   function automatic void format_input_byte(input byte_type c);
      text_result_type r;
      step_bytes.delete();
      if (line_head && c == CH_NEWLINE) begin
         if (opt_squeeze_blank && empty_streak) begin
            return;
         end
         if (opt_number_mode == NUM_ALL) begin
            push_line_label();
         end
         emit_newline();
         empty_streak = 1'b1;
      end else begin
         if (line_head) begin
            if (opt_squeeze_blank) begin
               empty_streak = 1'b0;
            end
            if (opt_number_mode != NUM_NONE) begin
               push_line_label();
            end
            line_head = 1'b0;
         end
         if (c == CH_NEWLINE) begin
            emit_newline();
            line_head = 1'b1;
         end else begin
            emit_visible(c);
         end
      end
      foreach (step_bytes[i]) begin
         r.out_byte = step_bytes[i];
         r.last = (i == step_bytes.size() - 1);
         expected_output.push_back(r);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [8:0] want,
                                  input logic [8:0] got);
      if (mismatch_count < 10) begin
         $display("%0t: %s: expected %h, got %h", $time, what, want, got);
      end
      mismatch_count++;
   endtask

   task automatic send_text_byte(input byte_type c);
      @(negedge clock);
      req_valid <= 1'b1;
      req_in_byte <= c;
      do @(posedge clock); while (!req_ready);
      format_input_byte(c);
      items_sent++;
      if (gaps_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 20);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end
      end
   endtask

   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_output.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_option(input logic [2:0] index, input logic [1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (index)
         CSR_NUMBER_MODE:      opt_number_mode = value;
         CSR_SQUEEZE_BLANK:    opt_squeeze_blank = value[0];
         CSR_SHOW_ENDS:        opt_show_ends = value[0];
         CSR_CARET_TABS:       opt_caret_tabs = value[0];
         CSR_SHOW_NONPRINTING: opt_show_nonprinting = value[0];
         default: ;
      endcase
   endtask

   task automatic set_options(input logic [1:0] mode, input logic squeeze,
                              input logic ends, input logic tabs, input logic nonprint);
      wait_until_idle();
      write_option(CSR_NUMBER_MODE, mode);
      write_option(CSR_SQUEEZE_BLANK, {1'b0, squeeze});
      write_option(CSR_SHOW_ENDS, {1'b0, ends});
      write_option(CSR_CARET_TABS, {1'b0, tabs});
      write_option(CSR_SHOW_NONPRINTING, {1'b0, nonprint});
      settings_applied++;
   endtask

   function automatic byte_type random_text_byte();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         return CH_NEWLINE;
      end else if (pick < 22) begin
         return CH_TAB;
      end else if (pick < 32) begin
         return byte_type'($urandom_range(0, 255));
      end else if (pick < 40) begin
         return byte_type'($urandom_range(128, 255));
      end
      return byte_type'($urandom_range(32, 126));
   endfunction

   task automatic test_plain_passthrough();
      send_text_byte(CH_UPPER_I);
      send_text_byte(CH_TAB);
      send_text_byte(8'h00);
      send_text_byte(8'hff);
      send_text_byte(CH_NEWLINE);
   endtask

   task automatic test_escape_forms();
      set_options(NUM_ALL, 1'b0, 1'b1, 1'b1, 1'b1);
      send_text_byte(CH_TAB);
      send_text_byte(8'h89);
      send_text_byte(LOW_MASK);
      send_text_byte(8'hff);
      send_text_byte(HIGH_BIT);
      send_text_byte(8'h1f);
      send_text_byte(CH_SPACE);
      send_text_byte(8'h7e);
      send_text_byte(CH_NEWLINE);
      send_text_byte(CH_NEWLINE);
   endtask

   // Mode three numbers only non-blank lines; the tab stays raw without caret tabs.
   task automatic test_blank_squeeze();
      set_options(NUM_NONBLANK_ALT, 1'b1, 1'b0, 1'b0, 1'b1);
      send_text_byte(CH_TAB);
      send_text_byte(CH_NEWLINE);
      send_text_byte(CH_NEWLINE);
      send_text_byte(CH_NEWLINE);
      send_text_byte(CH_NEWLINE);
      send_text_byte(CH_LOWER_X);
      send_text_byte(CH_NEWLINE);
   endtask

   task automatic test_random_text();
      int sent;
      int pct_pick;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0) begin
            set_options(NUM_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
         end else if (phase == 1) begin
            set_options(NUM_NONBLANK_ALT, 1'b1, 1'b1, 1'b1, 1'b1);
         end else begin
            set_options(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                        1'($urandom), 1'($urandom));
         end
         gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
         pct_pick = $urandom_range(0, 2);
         stall_pct = (phase == 0) ? 0 : (pct_pick == 0) ? 0 : (pct_pick == 1) ? 20 : 50;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(2, 4)) begin
                  send_text_byte(CH_NEWLINE);
                  sent++;
               end
            end else begin
               send_text_byte(random_text_byte());
               sent++;
            end
         end
      end
      gaps_on = 0;
      stall_pct = 0;
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      text_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         bytes_checked++;
         if (expected_output.size() == 0) begin
            report_mismatch("output byte with nothing expected", 9'h000,
                            {rsp_out_byte, rsp_last});
         end else begin
            want = expected_output.pop_front();
            if (want.out_byte !== rsp_out_byte) begin
               report_mismatch("out_byte", {1'b0, want.out_byte}, {1'b0, rsp_out_byte});
            end
            if (want.last !== rsp_last) begin
               report_mismatch("last", {8'h00, want.last}, {8'h00, rsp_last});
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles.", idle_cycles);
         $display("FAIL text_line_number_escape_filter");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      csr_write_en = 1'b0;
      csr_index = CSR_NUMBER_MODE;
      csr_wdata = 2'd0;
      opt_number_mode = NUM_NONE;
      opt_squeeze_blank = 1'b0;
      opt_show_ends = 1'b0;
      opt_caret_tabs = 1'b0;
      opt_show_nonprinting = 1'b0;
      line_number = {{(4*LINE_DIGITS-1){1'b0}}, 1'b1};
      line_head = 1'b1;
      empty_streak = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_plain_passthrough();
      test_escape_forms();
      test_blank_squeeze();
      test_random_text();

      wait_until_idle();
      repeat (16) @(posedge clock);
      $display("Sent %0d input bytes under %0d option settings; checked %0d output bytes.",
               items_sent, settings_applied + 1, bytes_checked);
      $display("Line counter ended at %0h.", line_number);
      if (mismatch_count == 0) begin
         $display("PASS text_line_number_escape_filter");
      end else begin
         $display("%0d mismatches in total.", mismatch_count);
         $display("FAIL text_line_number_escape_filter");
      end
      $finish;
   end

endmodule
